@@ rtl/vse_pkg.sv @@
`default_nettype none

package vse_pkg;

  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned NORM_W     = ACC_W / 2;
  localparam int unsigned PROD_W     = 2 * (ELEM_W + 1);
  localparam int unsigned DIVD_W     = ELEM_W + FRAC_BITS;
  localparam int unsigned REM_W      = NORM_W + 3;
  localparam int unsigned SQRT_STEPS = ACC_W / 2;
  localparam int unsigned MAX_STEPS  = (DIVD_W > SQRT_STEPS) ? DIVD_W : SQRT_STEPS;
  localparam int unsigned STEP_W     = $clog2(MAX_STEPS);

  localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic [DIVD_W-1:0] QPOS_MAX = {{(DIVD_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
  localparam logic [DIVD_W-1:0] QNEG_MAX = {{(DIVD_W-ELEM_W){1'b0}}, 1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_DOT,
    FUNC_L2,
    FUNC_NORM,
    FUNC_SCALE
  } func_e;

  typedef struct packed {
    logic              start;
    logic              is_div;
    logic [ACC_W-1:0]  radicand;
    logic [DIVD_W-1:0] dividend;
    logic [NORM_W-1:0] divisor;
  } iter_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
  } iter_rsp_t;

endpackage

`default_nettype wire

@@ rtl/vse_iter.sv @@
`default_nettype none

module vse_iter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vse_pkg::iter_req_t req_i,
  output vse_pkg::iter_rsp_t      rsp_o
);

  logic [vse_pkg::REM_W-1:0]  rem_q;
  logic [vse_pkg::ACC_W-1:0]  shf_q;
  logic [vse_pkg::DIVD_W-1:0] quo_q;
  logic [vse_pkg::NORM_W-1:0] dvs_q;
  logic [vse_pkg::STEP_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       is_div_q;
  logic                       done_q;

  logic [vse_pkg::REM_W-1:0]  part;
  logic [vse_pkg::REM_W-1:0]  subtr;
  logic [vse_pkg::REM_W:0]    diff;
  logic                       fits;

  always_comb begin
    if (is_div_q) begin
      part  = {rem_q[vse_pkg::REM_W-2:0], shf_q[vse_pkg::ACC_W-1]};
      subtr = {3'b000, dvs_q};
    end else begin
      part  = {rem_q[vse_pkg::REM_W-3:0], shf_q[vse_pkg::ACC_W-1 -: 2]};
      subtr = {1'b0, quo_q[vse_pkg::NORM_W-1:0], 2'b01};
    end
    diff = {1'b0, part} - {1'b0, subtr};
    fits = !diff[vse_pkg::REM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      shf_q    <= '0;
      quo_q    <= '0;
      dvs_q    <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      is_div_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q    <= '0;
        quo_q    <= '0;
        dvs_q    <= req_i.divisor;
        is_div_q <= req_i.is_div;
        busy_q   <= 1'b1;
        if (req_i.is_div) begin
          shf_q <= {req_i.dividend, {(vse_pkg::ACC_W-vse_pkg::DIVD_W){1'b0}}};
          cnt_q <= vse_pkg::STEP_W'(vse_pkg::DIVD_W - 1);
        end else begin
          shf_q <= req_i.radicand;
          cnt_q <= vse_pkg::STEP_W'(vse_pkg::SQRT_STEPS - 1);
        end
      end else if (busy_q) begin
        rem_q <= fits ? diff[vse_pkg::REM_W-1:0] : part;
        quo_q <= {quo_q[vse_pkg::DIVD_W-2:0], fits};
        shf_q <= is_div_q ? {shf_q[vse_pkg::ACC_W-2:0], 1'b0}
                          : {shf_q[vse_pkg::ACC_W-3:0], 2'b00};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

@@ rtl/vector_similarity_engine.sv @@
// An accumulating request passes through the multiply and accumulate states before the block is ready again.
// A last request of the dot product or distance modes passes through the multiply, accumulate and result states.
// A last norm request with a positive sum also takes the bit-pair square root in the shared iterative unit.
// A scale request with a nonzero stored norm runs the 28 restoring division steps of that unit.
// One request is in flight at a time; the output register holds a result while the next request enters.
// Reset is asynchronous and clears the accumulator, the count, the flag and the stored norm.
`default_nettype none

module vector_similarity_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   func_i,
  input  wire logic [vse_pkg::ELEM_W-1:0]   a_elem_i,
  input  wire logic [vse_pkg::ELEM_W-1:0]   b_elem_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [vse_pkg::ACC_W-1:0]         sum_value_o,
  output logic [vse_pkg::NORM_W-1:0]        norm_value_o,
  output logic [vse_pkg::ELEM_W-1:0]        scaled_elem_o,
  output logic [vse_pkg::CNT_W-1:0]         element_count_o,
  output logic                              overflow_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ROOT,
    S_DIV,
    S_RESULT
  } state_e;

  state_e                      state_q;
  vse_pkg::func_e              func_q;
  logic [vse_pkg::ELEM_W-1:0]  a_q;
  logic [vse_pkg::ELEM_W-1:0]  b_q;
  logic                        last_q;
  logic [vse_pkg::PROD_W-1:0]  prod_q;
  logic [vse_pkg::ACC_W-1:0]   acc_q;
  logic [vse_pkg::CNT_W-1:0]   cnt_q;
  logic                        sat_q;
  logic [vse_pkg::NORM_W-1:0]  norm_q;

  logic [vse_pkg::ACC_W-1:0]   res_sum_q;
  logic [vse_pkg::NORM_W-1:0]  res_norm_q;
  logic [vse_pkg::ELEM_W-1:0]  res_scaled_q;
  logic [vse_pkg::CNT_W-1:0]   res_cnt_q;
  logic                        res_ovf_q;

  logic                        out_valid_q;
  logic [vse_pkg::ACC_W-1:0]   out_sum_q;
  logic [vse_pkg::NORM_W-1:0]  out_norm_q;
  logic [vse_pkg::ELEM_W-1:0]  out_scaled_q;
  logic [vse_pkg::CNT_W-1:0]   out_cnt_q;
  logic                        out_ovf_q;

  logic signed [vse_pkg::ELEM_W:0]   op_x;
  logic signed [vse_pkg::ELEM_W:0]   op_y;
  logic signed [vse_pkg::PROD_W-1:0] prod_d;
  logic [vse_pkg::ACC_W:0]           sum_ext;
  logic                              acc_ovf;
  logic [vse_pkg::ACC_W-1:0]         acc_new;
  logic                              cnt_full;
  logic [vse_pkg::CNT_W-1:0]         cnt_new;
  logic                              sat_new;
  logic                              acc_pos;
  logic [vse_pkg::ELEM_W-1:0]        mag;
  logic                              q_pos_big;
  logic                              q_neg_big;
  logic [vse_pkg::ELEM_W-1:0]        q_low;
  logic                              accept;

  vse_pkg::iter_req_t iter_req;
  vse_pkg::iter_rsp_t iter_rsp;

  vse_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    unique case (func_q)
      vse_pkg::FUNC_DOT: begin
        op_x = $signed({a_q[vse_pkg::ELEM_W-1], a_q});
        op_y = $signed({b_q[vse_pkg::ELEM_W-1], b_q});
      end
      vse_pkg::FUNC_L2: begin
        op_x = $signed({a_q[vse_pkg::ELEM_W-1], a_q} - {b_q[vse_pkg::ELEM_W-1], b_q});
        op_y = op_x;
      end
      vse_pkg::FUNC_NORM, vse_pkg::FUNC_SCALE: begin
        op_x = $signed({a_q[vse_pkg::ELEM_W-1], a_q});
        op_y = op_x;
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
    prod_d = op_x * op_y;
  end

  always_comb begin
    sum_ext  = {{(vse_pkg::ACC_W+1-vse_pkg::PROD_W){prod_q[vse_pkg::PROD_W-1]}}, prod_q}
             + {acc_q[vse_pkg::ACC_W-1], acc_q};
    acc_ovf  = sum_ext[vse_pkg::ACC_W] ^ sum_ext[vse_pkg::ACC_W-1];
    if (acc_ovf) begin
      acc_new = sum_ext[vse_pkg::ACC_W] ? vse_pkg::ACC_MIN : vse_pkg::ACC_MAX;
    end else begin
      acc_new = sum_ext[vse_pkg::ACC_W-1:0];
    end
    cnt_full = &cnt_q;
    cnt_new  = cnt_full ? cnt_q : cnt_q + 1'b1;
    sat_new  = sat_q | acc_ovf | cnt_full;
    acc_pos  = !acc_new[vse_pkg::ACC_W-1] && (|acc_new);
    mag      = a_q[vse_pkg::ELEM_W-1] ? ({vse_pkg::ELEM_W{1'b0}} - a_q) : a_q;
    q_pos_big = iter_rsp.quot > vse_pkg::QPOS_MAX;
    q_neg_big = iter_rsp.quot > vse_pkg::QNEG_MAX;
    q_low     = iter_rsp.quot[vse_pkg::ELEM_W-1:0];
  end

  always_comb begin
    iter_req.start    = ((state_q == S_MUL) && (func_q == vse_pkg::FUNC_SCALE) && (|norm_q))
                     || ((state_q == S_ACC) && last_q && (func_q == vse_pkg::FUNC_NORM)
                         && acc_pos);
    iter_req.is_div   = (state_q == S_MUL);
    iter_req.radicand = acc_new;
    iter_req.dividend = {mag, {vse_pkg::FRAC_BITS{1'b0}}};
    iter_req.divisor  = norm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= vse_pkg::FUNC_DOT;
      a_q          <= '0;
      b_q          <= '0;
      last_q       <= 1'b0;
      prod_q       <= '0;
      acc_q        <= '0;
      cnt_q        <= '0;
      sat_q        <= 1'b0;
      norm_q       <= '0;
      res_sum_q    <= '0;
      res_norm_q   <= '0;
      res_scaled_q <= '0;
      res_cnt_q    <= '0;
      res_ovf_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sum_q    <= '0;
      out_norm_q   <= '0;
      out_scaled_q <= '0;
      out_cnt_q    <= '0;
      out_ovf_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q  <= vse_pkg::func_e'(func_i);
            a_q     <= a_elem_i;
            b_q     <= b_elem_i;
            last_q  <= last_i;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= vse_pkg::PROD_W'(prod_d);
          if (func_q == vse_pkg::FUNC_SCALE) begin
            res_sum_q    <= '0;
            res_norm_q   <= '0;
            res_cnt_q    <= '0;
            res_scaled_q <= a_q;
            res_ovf_q    <= 1'b0;
            state_q      <= (|norm_q) ? S_DIV : S_RESULT;
          end else begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (last_q) begin
            res_sum_q    <= acc_new;
            res_norm_q   <= '0;
            res_scaled_q <= '0;
            res_cnt_q    <= cnt_new;
            res_ovf_q    <= sat_new;
            acc_q        <= '0;
            cnt_q        <= '0;
            sat_q        <= 1'b0;
            if (func_q == vse_pkg::FUNC_NORM) begin
              if (acc_pos) begin
                state_q <= S_ROOT;
              end else begin
                norm_q  <= '0;
                state_q <= S_RESULT;
              end
            end else begin
              state_q <= S_RESULT;
            end
          end else begin
            acc_q   <= acc_new;
            cnt_q   <= cnt_new;
            sat_q   <= sat_new;
            state_q <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (iter_rsp.done) begin
            res_norm_q <= iter_rsp.quot[vse_pkg::NORM_W-1:0];
            norm_q     <= iter_rsp.quot[vse_pkg::NORM_W-1:0];
            state_q    <= S_RESULT;
          end
        end
        S_DIV: begin
          if (iter_rsp.done) begin
            if (a_q[vse_pkg::ELEM_W-1]) begin
              res_scaled_q <= q_neg_big ? vse_pkg::ELEM_MIN : ({vse_pkg::ELEM_W{1'b0}} - q_low);
              res_ovf_q    <= q_neg_big;
            end else begin
              res_scaled_q <= q_pos_big ? vse_pkg::ELEM_MAX : q_low;
              res_ovf_q    <= q_pos_big;
            end
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_sum_q    <= res_sum_q;
            out_norm_q   <= res_norm_q;
            out_scaled_q <= res_scaled_q;
            out_cnt_q    <= res_cnt_q;
            out_ovf_q    <= res_ovf_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign sum_value_o     = out_sum_q;
  assign norm_value_o    = out_norm_q;
  assign scaled_elem_o   = out_scaled_q;
  assign element_count_o = out_cnt_q;
  assign overflow_o      = out_ovf_q;

endmodule

`default_nettype wire

@@ rtl/vse_checker.sv @@
`default_nettype none

module vse_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic [1:0]                   func_i,
  input wire logic [vse_pkg::ELEM_W-1:0]   a_elem_i,
  input wire logic [vse_pkg::ELEM_W-1:0]   b_elem_i,
  input wire logic                         last_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [vse_pkg::ACC_W-1:0]    sum_value_o,
  input wire logic [vse_pkg::NORM_W-1:0]   norm_value_o,
  input wire logic [vse_pkg::ELEM_W-1:0]   scaled_elem_o,
  input wire logic [vse_pkg::CNT_W-1:0]    element_count_o,
  input wire logic                         overflow_o
);

  logic unused_inputs;
  assign unused_inputs = ^{func_i, a_elem_i, b_elem_i, last_i, overflow_o};

  // A result that waits on a stalled receiver is not withdrawn.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // Once it accepts a request, the block is busy and stalls its input.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready directly after accepting a request");

  // A new result only appears while a request is being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

  // A scaled element never shares a result with a sum or a count.
  a_scale_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (scaled_elem_o != '0) |-> (sum_value_o == '0) && (element_count_o == '0))
    else $error("scaled element mixed with an accumulated result");

  // A norm comes only from a vector of at least one element.
  a_norm_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (norm_value_o != '0) |-> (element_count_o != '0) && (scaled_elem_o == '0))
    else $error("norm given without a counted vector");

endmodule

bind vector_similarity_engine vse_checker u_vse_checker (.*);

`default_nettype wire

@@ tb/sv/vector_similarity_engine_test.sv @@
`timescale 1ns / 100ps

module vector_similarity_engine_test;

  typedef struct packed {
    logic [vse_pkg::ACC_W-1:0]  acc_sum;
    logic [vse_pkg::NORM_W-1:0] norm;
    logic [vse_pkg::ELEM_W-1:0] scaled;
    logic [vse_pkg::CNT_W-1:0]  elems;
    logic                       ovf;
  } sim_result_t;

  typedef struct packed {
    vse_pkg::func_e             f;
    logic [vse_pkg::ELEM_W-1:0] a;
    logic [vse_pkg::ELEM_W-1:0] b;
    logic                       last;
    logic                       typed;
    sim_result_t                res;
  } stim_row_t;

  localparam sim_result_t NO_RES = '0;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam longint ELEM_HI = (longint'(1) << (vse_pkg::ELEM_W - 1)) - 1;
  localparam longint ELEM_LO = -ELEM_HI - 1;
  localparam longint ACC_HI = (longint'(1) << (vse_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam int unsigned CNT_HI = (1 << vse_pkg::CNT_W) - 1;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 func_i;
  logic [vse_pkg::ELEM_W-1:0] a_elem_i;
  logic [vse_pkg::ELEM_W-1:0] b_elem_i;
  logic                       last_i;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [vse_pkg::ACC_W-1:0]  sum_value_o;
  logic [vse_pkg::NORM_W-1:0] norm_value_o;
  logic [vse_pkg::ELEM_W-1:0] scaled_elem_o;
  logic [vse_pkg::CNT_W-1:0]  element_count_o;
  logic                       overflow_o;

  longint                     run_sum = 0;
  int unsigned                run_count = 0;
  bit                         run_sat = 1'b0;
  logic [vse_pkg::NORM_W-1:0] held_norm = '0;

  sim_result_t sim_results_q [$];
  logic        typed_on = 1'b0;
  sim_result_t typed_res = '0;
  int          faults = 0;
  int          sent_total = 0;
  int          scaled_predicted = 0;
  int          sums_predicted = 0;
  int unsigned cycle_count = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic        rx_calm = 1'b0;
  int          hold_left = 0;

  vector_similarity_engine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .a_elem_i       (a_elem_i),
    .b_elem_i       (b_elem_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sum_value_o    (sum_value_o),
    .norm_value_o   (norm_value_o),
    .scaled_elem_o  (scaled_elem_o),
    .element_count_o(element_count_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit fold_element(input vse_pkg::func_e f,
                                      input logic [vse_pkg::ELEM_W-1:0] a_raw,
                                      input logic [vse_pkg::ELEM_W-1:0] b_raw,
                                      input logic last, output sim_result_t res);
    longint a;
    longint b;
    longint d;
    longint term;
    longint mag;
    longint q;
    longint nrm;
    longint t;
    a = $signed(a_raw);
    b = $signed(b_raw);
    res = NO_RES;
    if (f == vse_pkg::FUNC_SCALE) begin
      if (held_norm == '0) begin
        q = a;
      end else begin
        mag = (a < 0) ? -a : a;
        q = (mag << vse_pkg::FRAC_BITS) / longint'(held_norm);
        if (a < 0) q = -q;
      end
      if (q > ELEM_HI) begin
        q = ELEM_HI;
        res.ovf = 1'b1;
      end
      if (q < ELEM_LO) begin
        q = ELEM_LO;
        res.ovf = 1'b1;
      end
      res.scaled = q[vse_pkg::ELEM_W-1:0];
      return 1'b1;
    end
    case (f)
      vse_pkg::FUNC_DOT: term = a * b;
      vse_pkg::FUNC_L2: begin
        d = a - b;
        term = d * d;
      end
      default: term = a * a;
    endcase
    if (term > 0 && run_sum > ACC_HI - term) begin
      run_sum = ACC_HI;
      run_sat = 1'b1;
    end else if (term < 0 && run_sum < ACC_LO - term) begin
      run_sum = ACC_LO;
      run_sat = 1'b1;
    end else begin
      run_sum += term;
    end
    if (run_count >= CNT_HI) run_sat = 1'b1;
    else run_count++;
    if (!last) return 1'b0;
    nrm = 0;
    if (f == vse_pkg::FUNC_NORM) begin
      for (int i = vse_pkg::NORM_W - 1; i >= 0; i--) begin
        t = nrm | (longint'(1) << i);
        if (t * t <= run_sum) nrm = t;
      end
      held_norm = nrm[vse_pkg::NORM_W-1:0];
    end
    res.acc_sum = run_sum[vse_pkg::ACC_W-1:0];
    res.norm = nrm[vse_pkg::NORM_W-1:0];
    res.elems = run_count[vse_pkg::CNT_W-1:0];
    res.ovf = run_sat;
    run_sum = 0;
    run_count = 0;
    run_sat = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [vse_pkg::ELEM_W-1:0] rand_elem();
    logic [31:0] r;
    r = $urandom;
    case (r[31:29])
      3'd0: return vse_pkg::ELEM_MIN;
      3'd1: return vse_pkg::ELEM_MAX;
      3'd2, 3'd3: return {{(vse_pkg::ELEM_W - 7){r[6]}}, r[6:0]};
      default: return r[vse_pkg::ELEM_W-1:0];
    endcase
  endfunction

  function automatic int vec_len();
    if ($urandom_range(9) == 0) return $urandom_range(48, 9);
    return $urandom_range(8, 1);
  endfunction

  task automatic send_request(input stim_row_t row, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 16) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    func_i <= row.f;
    a_elem_i <= row.a;
    b_elem_i <= row.b;
    last_i <= row.last;
    typed_on <= row.typed;
    typed_res <= row.res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_total++;
  endtask

  // The long hold-off lets the output register fill so that the block must stall its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !rx_calm && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk_i) begin : watch
    sim_result_t fresh;
    sim_result_t want;
    sim_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (fold_element(vse_pkg::func_e'(func_i), a_elem_i, b_elem_i, last_i, fresh)) begin
          if (typed_on) fresh = typed_res;
          if (vse_pkg::func_e'(func_i) == vse_pkg::FUNC_SCALE) scaled_predicted++;
          else sums_predicted++;
          sim_results_q.push_back(fresh);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got = {sum_value_o, norm_value_o, scaled_elem_o, element_count_o, overflow_o};
        if (sim_results_q.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("cycle %0d: unexpected result sum %h norm %h scaled %h count %0d ovf %b",
                     cycle_count, got.acc_sum, got.norm, got.scaled, got.elems, got.ovf);
        end else begin
          want = sim_results_q.pop_front();
          if (got.acc_sum !== want.acc_sum || got.norm !== want.norm ||
              got.scaled !== want.scaled || got.elems !== want.elems || got.ovf !== want.ovf) begin
            faults++;
            if (faults <= 10)
              $display("cycle %0d: got sum %h norm %h scaled %h count %0d ovf %b, %s",
                       cycle_count, got.acc_sum, got.norm, got.scaled, got.elems, got.ovf,
                       $sformatf("expected sum %h norm %h scaled %h count %0d ovf %b",
                                 want.acc_sum, want.norm, want.scaled, want.elems, want.ovf));
          end
        end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : drive
    stim_row_t      plan [DIRECTED_ROWS];
    vse_pkg::func_e f;
    int             len;
    int             pick;
    int             rand_base;
    bit             calm;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = vse_pkg::FUNC_DOT;
    a_elem_i = '0;
    b_elem_i = '0;
    last_i = 1'b0;

    plan[0]  = {vse_pkg::FUNC_SCALE, 16'h8000, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'h8000, 16'd0, 1'b0};
    plan[1]  = {vse_pkg::FUNC_SCALE, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1,
                48'h0, 24'h0, 16'h7FFF, 16'd0, 1'b0};
    plan[2]  = {vse_pkg::FUNC_DOT, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1,
                48'h3FFF0001, 24'h0, 16'h0, 16'd1, 1'b0};
    plan[3]  = {vse_pkg::FUNC_DOT, 16'h8000, 16'h8000, 1'b0, 1'b0, NO_RES};
    plan[4]  = {vse_pkg::FUNC_DOT, 16'h8000, 16'h7FFF, 1'b1, 1'b1,
                48'h8000, 24'h0, 16'h0, 16'd2, 1'b0};
    plan[5]  = {vse_pkg::FUNC_L2, 16'h8000, 16'h7FFF, 1'b1, 1'b1,
                48'hFFFE0001, 24'h0, 16'h0, 16'd1, 1'b0};
    plan[6]  = {vse_pkg::FUNC_L2, 16'h7FFF, 16'h8000, 1'b1, 1'b1,
                48'hFFFE0001, 24'h0, 16'h0, 16'd1, 1'b0};
    plan[7]  = {vse_pkg::FUNC_L2, 16'h1234, 16'h1234, 1'b1, 1'b1,
                48'h0, 24'h0, 16'h0, 16'd1, 1'b0};
    plan[8]  = {vse_pkg::FUNC_NORM, 16'h1000, 16'h0000, 1'b1, 1'b1,
                48'h1000000, 24'h1000, 16'h0, 16'd1, 1'b0};
    plan[9]  = {vse_pkg::FUNC_SCALE, 16'h1000, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'h1000, 16'd0, 1'b0};
    plan[10] = {vse_pkg::FUNC_SCALE, 16'h8000, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'h8000, 16'd0, 1'b0};
    plan[11] = {vse_pkg::FUNC_NORM, 16'h0800, 16'h0000, 1'b1, 1'b1,
                48'h400000, 24'h800, 16'h0, 16'd1, 1'b0};
    plan[12] = {vse_pkg::FUNC_SCALE, 16'h4000, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'h7FFF, 16'd0, 1'b1};
    plan[13] = {vse_pkg::FUNC_SCALE, 16'hC000, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'h8000, 16'd0, 1'b0};
    plan[14] = {vse_pkg::FUNC_SCALE, 16'hBFFF, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'h8000, 16'd0, 1'b1};
    plan[15] = {vse_pkg::FUNC_NORM, 16'h0001, 16'hFFFF, 1'b1, 1'b1,
                48'h1, 24'h1, 16'h0, 16'd1, 1'b0};
    plan[16] = {vse_pkg::FUNC_SCALE, 16'hFFFF, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'hF000, 16'd0, 1'b0};
    plan[17] = {vse_pkg::FUNC_DOT, 16'h8000, 16'h7FFF, 1'b0, 1'b0, NO_RES};
    plan[18] = {vse_pkg::FUNC_NORM, 16'h0000, 16'h0000, 1'b1, 1'b1,
                48'hFFFFC0008000, 24'h0, 16'h0, 16'd2, 1'b0};
    plan[19] = {vse_pkg::FUNC_SCALE, 16'h1234, 16'h0000, 1'b0, 1'b1,
                48'h0, 24'h0, 16'h1234, 16'd0, 1'b0};
    plan[20] = {vse_pkg::FUNC_NORM, 16'h0100, 16'h0000, 1'b0, 1'b0, NO_RES};
    plan[21] = {vse_pkg::FUNC_L2, 16'h0000, 16'h0100, 1'b0, 1'b0, NO_RES};
    plan[22] = {vse_pkg::FUNC_DOT, 16'h0100, 16'h0200, 1'b1, 1'b0, NO_RES};
    plan[23] = {vse_pkg::FUNC_NORM, 16'h8000, 16'h5555, 1'b1, 1'b1,
                48'h40000000, 24'h8000, 16'h0, 16'd1, 1'b0};
    plan[24] = {vse_pkg::FUNC_SCALE, 16'h7FFF, 16'hAAAA, 1'b0, 1'b0, NO_RES};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_request(plan[i], 1'b1);

    rand_base = sent_total;
    while (sent_total - rand_base < RANDOM_ITEMS) begin
      calm = (sent_total - rand_base >= 600) && (sent_total - rand_base < 850);
      hold_req <= (sent_total - rand_base >= 300);
      rx_calm <= calm;
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_request({vse_pkg::func_e'($urandom_range(3)), rand_elem(), rand_elem(),
                      1'($urandom_range(1)), 1'b0, NO_RES}, !calm);
      end else if (pick < 40) begin
        len = vec_len();
        for (int i = 0; i < len; i++)
          send_request({vse_pkg::FUNC_NORM, rand_elem(), 16'($urandom), i == len - 1, 1'b0,
                        NO_RES}, !calm);
        len = vec_len();
        for (int i = 0; i < len; i++)
          send_request({vse_pkg::FUNC_SCALE, rand_elem(), 16'($urandom), 1'($urandom_range(1)),
                        1'b0, NO_RES}, !calm);
      end else begin
        f = vse_pkg::func_e'($urandom_range(1));
        len = vec_len();
        for (int i = 0; i < len; i++)
          send_request({f, rand_elem(), rand_elem(), i == len - 1, 1'b0, NO_RES}, !calm);
      end
    end

    in_valid_i <= 1'b0;
    while (sim_results_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests: %0d directed rows and %0d random vectors and scalings.",
             sent_total, DIRECTED_ROWS, sent_total - rand_base);
    $display("Predicted %0d scaled elements and %0d vector sums; %0d mismatches in %0d cycles.",
             scaled_predicted, sums_predicted, faults, cycle_count);
    if (faults == 0 && sim_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
